@@ src/gzts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzts_pkg
// Shared types, constants and fixed-point helpers for the gaze target select.
// ----------------------------------------------------------------------------
package gzts_pkg;

    localparam int MARKER_LIMIT = 64;
    localparam int CNT_W        = $clog2(MARKER_LIMIT + 1);
    localparam int IDX_W        = 6;
    localparam int CFG_W        = 31;
    localparam int DIVD_W       = 48;
    localparam int DIVS_W       = 33;

    localparam logic [CFG_W-1:0] MAX_DIST_RST = 31'd65536;
    localparam logic [CFG_W-1:0] CONF_THR_RST = 31'd6554;

    // depth scaling: (mm*65536 + 500) / 1000 == ((mm << 13) + 62) / 125,
    // and the divide by 125 is exact as a multiply by ceil(2^36/125) >> 36
    // for every 16-bit depth
    localparam logic [31:0]        DEPTH_BIAS  = 32'd62;
    localparam logic signed [31:0] DEPTH_RECIP = 32'sd549755814;
    localparam int                 DEPTH_SHIFT = 36;

    localparam logic CFG_MAX_DIST = 1'b0;
    localparam logic CFG_CONF_THR = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ZDIV, ST_XX, ST_ZY, ST_D1, ST_D2, ST_D3, ST_D4,
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_D5,
        ST_E0, ST_S0, ST_E1, ST_S1, ST_E2, ST_S2, ST_SQ, ST_FIN
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
        logic              neg;
    } div_req_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p >>> 16;
        if (p[63] && (p[15:0] != 16'd0))
            q = q + 64'sd1;
        return sat64(q);
    endfunction

endpackage

@@ src/gzts_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzts_div
// Restoring divider, one quotient bit per cycle, saturated signed result.
// ----------------------------------------------------------------------------
module gzts_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  gzts_pkg::div_req_t  req,
    output logic                done,
    output logic signed [31:0]  quot
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [5:0]                    cnt_reg, cnt_next;
    logic [gzts_pkg::DIVS_W-1:0]   rem_reg, rem_next;
    logic [gzts_pkg::DIVD_W-1:0]   q_reg, q_next;
    logic [gzts_pkg::DIVS_W-1:0]   d_reg, d_next;
    logic                          neg_reg, neg_next;
    logic [gzts_pkg::DIVS_W:0]     shifted;
    logic [gzts_pkg::DIVS_W:0]     diff;

    assign shifted = {rem_reg, q_reg[gzts_pkg::DIVD_W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(gzts_pkg::DIVD_W - 1);
            rem_next  = '0;
            q_next    = req.dividend;
            d_next    = req.divisor;
            neg_next  = req.neg;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                rem_next = diff[gzts_pkg::DIVS_W-1:0];
                q_next   = {q_reg[gzts_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[gzts_pkg::DIVS_W-1:0];
                q_next   = {q_reg[gzts_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            if (q_reg > 48'h00007fffffff)
                quot = 32'sh7fffffff;
            else
                quot = q_reg[31:0];
        end
        else
        begin
            if (q_reg >= 48'h000080000000)
                quot = 32'sh80000000;
            else
                quot = -$signed(q_reg[31:0]);
        end
    end

    assign done = done_reg;

endmodule

@@ src/gzts_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gzts_sqrt
// Digit-by-digit integer square root of a 64-bit value, two bits per cycle.
// ----------------------------------------------------------------------------
module gzts_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] rad_reg, rad_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [35:0] trial;
    logic [35:0] sub;
    logic [35:0] diff;

    assign trial = {rem_reg, rad_reg[63:62]};
    assign sub   = {2'b00, root_reg, 2'b01};
    assign diff  = trial - sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= sub)
            begin
                rem_next  = diff[33:0];
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            rad_next = {rad_reg[61:0], 2'b00};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ src/gaze_ray_target_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaze_ray_target_select
// Picks the marker nearest to the head gaze ray, one result per frame.
// ----------------------------------------------------------------------------
// One marker is taken at a time; ready stays low while it is processed. A
// marker skipped on confidence or frame overflow goes from idle straight to
// the final state; a qualifying marker runs five serial divisions through the
// shared divider, a square root and steps on the shared 32x32 multiplier and
// bookkeeping. Depth scaling is a reciprocal multiply on that multiplier. The
// result of the item flagged last is held in an output register until
// transferred; while it waits, the next last item stalls.
module gaze_ray_target_select
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [gzts_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [31:0]          head_center_x,
    input  logic signed [31:0]          head_center_y,
    input  logic signed [31:0]          head_center_z,
    input  logic signed [31:0]          head_front_x,
    input  logic signed [31:0]          head_front_y,
    input  logic signed [31:0]          head_front_z,
    input  logic signed [31:0]          marker_x,
    input  logic signed [31:0]          marker_y,
    input  logic [15:0]                 marker_depth_mm,
    input  logic [30:0]                 marker_confidence,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          attended_x,
    output logic signed [31:0]          attended_y,
    output logic signed [31:0]          attended_z,
    output logic [gzts_pkg::IDX_W-1:0]  marker_index,
    output logic                        found
);

    gzts_pkg::state_t state_reg, state_next;

    logic [gzts_pkg::CFG_W-1:0] maxd_reg, thr_reg;
    logic [gzts_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [31:0] p1x_reg, p1y_reg, p1z_reg, p2x_reg, p2y_reg, p2z_reg;
    logic signed [31:0] mx_reg, my_reg;
    logic [15:0]        mm_reg;
    logic               last_reg, act_reg;

    logic signed [31:0] z_reg, z_next, xx_reg, xx_next, tmp_reg, tmp_next;
    logic signed [31:0] k_reg, k_next, m_reg, m_next, num_reg, num_next;
    logic signed [31:0] den_reg, den_next, t_reg, t_next, e_reg, e_next;
    logic [63:0]        sum_reg, sum_next;

    logic [31:0]              bestd_reg, bestd_next;
    logic signed [31:0]       bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic [gzts_pkg::IDX_W-1:0] bi_reg, bi_next;
    logic                     hb_reg, hb_next;

    logic               ov_reg, ov_next;
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [gzts_pkg::IDX_W-1:0] oi_reg, oi_next;
    logic               of_reg, of_next;

    logic               accept;
    logic               act_in;
    logic signed [31:0] dx, dy, dz;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [31:0] qm;

    logic               div_go;
    logic signed [31:0] div_a;
    logic signed [34:0] div_b;
    logic [31:0]        div_amag;
    logic [34:0]        div_bmag;
    gzts_pkg::div_req_t div_req;
    logic               div_done;
    logic signed [31:0] div_q;

    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic [31:0]        seg_len;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == gzts_pkg::ST_IDLE);
    assign act_in   = (cnt_reg < gzts_pkg::CNT_W'(gzts_pkg::MARKER_LIMIT))
                      && (marker_confidence > thr_reg);

    assign dx = gzts_pkg::sat64(64'(p2x_reg) - 64'(p1x_reg));
    assign dy = gzts_pkg::sat64(64'(p2y_reg) - 64'(p1y_reg));
    assign dz = gzts_pkg::sat64(64'(p2z_reg) - 64'(p1z_reg));

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            gzts_pkg::ST_ZDIV:
            begin
                mul_a = {3'b000, mm_reg, 13'd0} + gzts_pkg::DEPTH_BIAS;
                mul_b = gzts_pkg::DEPTH_RECIP;
            end
            gzts_pkg::ST_XX: begin mul_a = mx_reg;  mul_b = mx_reg; end
            gzts_pkg::ST_ZY: begin mul_a = z_reg;   mul_b = my_reg; end
            gzts_pkg::ST_M1: begin mul_a = p1x_reg; mul_b = k_reg;  end
            gzts_pkg::ST_M2: begin mul_a = p1y_reg; mul_b = m_reg;  end
            gzts_pkg::ST_M4: begin mul_a = dx;      mul_b = k_reg;  end
            gzts_pkg::ST_M5: begin mul_a = dy;      mul_b = m_reg;  end
            gzts_pkg::ST_E0: begin mul_a = t_reg;   mul_b = dx;     end
            gzts_pkg::ST_E1: begin mul_a = t_reg;   mul_b = dy;     end
            gzts_pkg::ST_E2: begin mul_a = t_reg;   mul_b = dz;     end
            gzts_pkg::ST_S0, gzts_pkg::ST_S1, gzts_pkg::ST_S2:
            begin
                mul_a = e_reg;
                mul_b = e_reg;
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;
    assign qm   = gzts_pkg::qmul(prod);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gzts_pkg::ST_IDLE:
                if (accept)
                    state_next = act_in ? gzts_pkg::ST_ZDIV : gzts_pkg::ST_FIN;
            gzts_pkg::ST_ZDIV:
                state_next = (mx_reg == 32'sd0) ? gzts_pkg::ST_FIN
                                                : gzts_pkg::ST_XX;
            gzts_pkg::ST_XX:
                state_next = (qm == 32'sd0) ? gzts_pkg::ST_FIN : gzts_pkg::ST_ZY;
            gzts_pkg::ST_ZY: state_next = gzts_pkg::ST_D1;
            gzts_pkg::ST_D1: if (div_done) state_next = gzts_pkg::ST_D2;
            gzts_pkg::ST_D2: if (div_done) state_next = gzts_pkg::ST_D3;
            gzts_pkg::ST_D3: if (div_done) state_next = gzts_pkg::ST_D4;
            gzts_pkg::ST_D4: if (div_done) state_next = gzts_pkg::ST_M1;
            gzts_pkg::ST_M1: state_next = gzts_pkg::ST_M2;
            gzts_pkg::ST_M2: state_next = gzts_pkg::ST_M3;
            gzts_pkg::ST_M3: state_next = gzts_pkg::ST_M4;
            gzts_pkg::ST_M4: state_next = gzts_pkg::ST_M5;
            gzts_pkg::ST_M5: state_next = gzts_pkg::ST_M6;
            gzts_pkg::ST_M6:
                state_next = (den_reg == 32'sd0) ? gzts_pkg::ST_FIN : gzts_pkg::ST_D5;
            gzts_pkg::ST_D5: if (div_done) state_next = gzts_pkg::ST_E0;
            gzts_pkg::ST_E0: state_next = gzts_pkg::ST_S0;
            gzts_pkg::ST_S0: state_next = gzts_pkg::ST_E1;
            gzts_pkg::ST_E1: state_next = gzts_pkg::ST_S1;
            gzts_pkg::ST_S1: state_next = gzts_pkg::ST_E2;
            gzts_pkg::ST_E2: state_next = gzts_pkg::ST_S2;
            gzts_pkg::ST_S2: state_next = gzts_pkg::ST_SQ;
            gzts_pkg::ST_SQ: if (sq_done) state_next = gzts_pkg::ST_FIN;
            gzts_pkg::ST_FIN:
                if (!last_reg || !ov_reg || out_ready)
                    state_next = gzts_pkg::ST_IDLE;
            default: state_next = gzts_pkg::ST_IDLE;
        endcase
    end

    // divider launch
    always_comb
    begin
        div_go  = 1'b0;
        div_a   = '0;
        div_b   = '0;
        unique case (state_reg)
            gzts_pkg::ST_ZY:
            begin
                div_go = 1'b1;
                div_a  = z_reg;
                div_b  = 35'(mx_reg);
            end
            gzts_pkg::ST_D1:
            begin
                div_go = div_done;
                div_a  = tmp_reg;
                div_b  = 35'(xx_reg) <<< 1;
            end
            gzts_pkg::ST_D2:
            begin
                div_go = div_done;
                div_a  = z_reg;
                div_b  = 35'(xx_reg) <<< 1;
            end
            gzts_pkg::ST_D3:
            begin
                div_go = div_done;
                div_a  = z_reg;
                div_b  = 35'(mx_reg) <<< 1;
            end
            gzts_pkg::ST_M6:
            begin
                div_go = (den_reg != 32'sd0);
                div_a  = num_reg;
                div_b  = 35'(den_reg);
            end
            default: ;
        endcase
    end

    assign div_amag = div_a[31] ? 32'(-div_a) : 32'(div_a);
    assign div_bmag = div_b[34] ? 35'(-div_b) : 35'(div_b);

    always_comb
    begin
        div_req.start    = div_go;
        div_req.dividend = {div_amag, 16'd0};
        div_req.divisor  = div_bmag[gzts_pkg::DIVS_W-1:0];
        div_req.neg      = div_a[31] ^ div_b[34];
    end

    gzts_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    assign sq_start = (state_reg == gzts_pkg::ST_S2);

    gzts_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum_next),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign seg_len = sq_root[31] ? 32'h7fffffff : sq_root;

    // datapath and frame state
    always_comb
    begin
        z_next   = z_reg;
        xx_next  = xx_reg;
        tmp_next = tmp_reg;
        k_next   = k_reg;
        m_next   = m_reg;
        num_next = num_reg;
        den_next = den_reg;
        t_next   = t_reg;
        e_next   = e_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        bestd_next = bestd_reg;
        bx_next  = bx_reg;
        by_next  = by_reg;
        bz_next  = bz_reg;
        bi_next  = bi_reg;
        hb_next  = hb_reg;
        ov_next  = ov_reg && !out_ready;
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        oz_next  = oz_reg;
        oi_next  = oi_reg;
        of_next  = of_reg;
        unique case (state_reg)
            gzts_pkg::ST_IDLE:
                if (accept && (cnt_reg == '0))
                    bestd_next = 32'(maxd_reg);
            gzts_pkg::ST_ZDIV: z_next = 32'(prod[63:gzts_pkg::DEPTH_SHIFT]);
            gzts_pkg::ST_XX:   xx_next  = qm;
            gzts_pkg::ST_ZY:   tmp_next = qm;
            gzts_pkg::ST_D1:   if (div_done) k_next = div_q;
            gzts_pkg::ST_D2, gzts_pkg::ST_D3:
                if (div_done)
                    k_next = gzts_pkg::sat64(64'(k_reg) + 64'(div_q));
            gzts_pkg::ST_D4:   if (div_done) m_next = div_q;
            gzts_pkg::ST_M1:   num_next = qm;
            gzts_pkg::ST_M2:
                num_next = gzts_pkg::sat64(64'(num_reg) - 64'(qm));
            gzts_pkg::ST_M3:
                num_next = gzts_pkg::sat64(
                    64'(gzts_pkg::sat64(64'(num_reg) - 64'(p1z_reg))) - 64'(m_reg));
            gzts_pkg::ST_M4:
                den_next = gzts_pkg::sat64(64'(dz) - 64'(qm));
            gzts_pkg::ST_M5:
                den_next = gzts_pkg::sat64(64'(den_reg) + 64'(qm));
            gzts_pkg::ST_D5:
                if (div_done)
                begin
                    t_next   = div_q;
                    sum_next = '0;
                end
            gzts_pkg::ST_E0:
                e_next = gzts_pkg::sat64(
                    64'(gzts_pkg::sat64(64'(p1x_reg) + 64'(qm))) - 64'(mx_reg));
            gzts_pkg::ST_E1:
                e_next = gzts_pkg::sat64(
                    64'(gzts_pkg::sat64(64'(p1y_reg) + 64'(qm))) - 64'(my_reg));
            gzts_pkg::ST_E2:
                e_next = gzts_pkg::sat64(
                    64'(gzts_pkg::sat64(64'(p1z_reg) + 64'(qm))) - 64'(z_reg));
            gzts_pkg::ST_S0, gzts_pkg::ST_S1, gzts_pkg::ST_S2:
                sum_next = sum_reg + 64'(prod);
            gzts_pkg::ST_SQ:
                if (sq_done && (seg_len < bestd_reg))
                begin
                    bestd_next = seg_len;
                    bx_next    = mx_reg;
                    by_next    = my_reg;
                    bz_next    = z_reg;
                    bi_next    = cnt_reg[gzts_pkg::IDX_W-1:0];
                    hb_next    = 1'b1;
                end
            gzts_pkg::ST_FIN:
            begin
                if (!last_reg)
                begin
                    if (act_reg || (cnt_reg < gzts_pkg::CNT_W'(gzts_pkg::MARKER_LIMIT)))
                        cnt_next = cnt_reg + 1'b1;
                end
                else if (!ov_reg || out_ready)
                begin
                    ov_next  = 1'b1;
                    ox_next  = hb_reg ? bx_reg : p1x_reg;
                    oy_next  = hb_reg ? by_reg : p1y_reg;
                    oz_next  = hb_reg ? bz_reg : p1z_reg;
                    oi_next  = hb_reg ? bi_reg : '0;
                    of_next  = hb_reg;
                    cnt_next = '0;
                    bx_next  = '0;
                    by_next  = '0;
                    bz_next  = '0;
                    bi_next  = '0;
                    hb_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gzts_pkg::ST_IDLE;
            maxd_reg  <= gzts_pkg::MAX_DIST_RST;
            thr_reg   <= gzts_pkg::CONF_THR_RST;
            cnt_reg   <= '0;
            bestd_reg <= 32'(gzts_pkg::MAX_DIST_RST);
            bx_reg    <= '0;
            by_reg    <= '0;
            bz_reg    <= '0;
            bi_reg    <= '0;
            hb_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    gzts_pkg::CFG_MAX_DIST: maxd_reg <= cfg_data;
                    gzts_pkg::CFG_CONF_THR: thr_reg  <= cfg_data;
                    default: ;
                endcase
            end
            cnt_reg   <= cnt_next;
            bestd_reg <= bestd_next;
            bx_reg    <= bx_next;
            by_reg    <= by_next;
            bz_reg    <= bz_next;
            bi_reg    <= bi_next;
            hb_reg    <= hb_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1x_reg  <= head_center_x;
            p1y_reg  <= head_center_y;
            p1z_reg  <= head_center_z;
            p2x_reg  <= head_front_x;
            p2y_reg  <= head_front_y;
            p2z_reg  <= head_front_z;
            mx_reg   <= marker_x;
            my_reg   <= marker_y;
            mm_reg   <= marker_depth_mm;
            last_reg <= last;
            act_reg  <= (cnt_reg < gzts_pkg::CNT_W'(gzts_pkg::MARKER_LIMIT));
        end
        z_reg   <= z_next;
        xx_reg  <= xx_next;
        tmp_reg <= tmp_next;
        k_reg   <= k_next;
        m_reg   <= m_next;
        num_reg <= num_next;
        den_reg <= den_next;
        t_reg   <= t_next;
        e_reg   <= e_next;
        sum_reg <= sum_next;
        ox_reg  <= ox_next;
        oy_reg  <= oy_next;
        oz_reg  <= oz_next;
        oi_reg  <= oi_next;
        of_reg  <= of_next;
    end

    assign out_valid    = ov_reg;
    assign attended_x   = ox_reg;
    assign attended_y   = oy_reg;
    assign attended_z   = oz_reg;
    assign marker_index = oi_reg;
    assign found        = of_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gaze_ray_target_select. Marker frames are pushed in
// through the valid/ready input, each accepted marker goes through a fixed-point
// copy of the gaze ray selection, and every frame result is checked field by
// field against the oldest predicted target. Idle and stall patterns on both
// sides change between some phases, and the config registers change between
// phases.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic signed [31:0] hcx, hcy, hcz, hfx, hfy, hfz, mx, my;
        logic [15:0]        mm;
        logic [30:0]        conf;
        logic               last;
    } marker_item_t;

    typedef struct {
        logic signed [31:0] ax, ay, az;
        logic [5:0]         idx;
        logic               found;
    } target_t;

    class frame_scoreboard;
        bit [30:0]   max_dist;
        bit [30:0]   conf_thr;
        longint      best_dist, best_x, best_y, best_z;
        int          best_idx;
        bit          have_best;
        int          count;
        target_t     targets_due[$];
        int          errors;

        function void reset_state();
            max_dist = gzts_pkg::MAX_DIST_RST;
            conf_thr = gzts_pkg::CONF_THR_RST;
            count    = 0;
            errors   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            best_dist = longint'(max_dist);
            best_x    = 0;
            best_y    = 0;
            best_z    = 0;
            best_idx  = 0;
            have_best = 0;
            count     = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint fmul(longint a, longint b);
            return sat((a * b) / 65536);
        endfunction

        function longint fdiv(longint a, longint b);
            return sat((a * 65536) / b);
        endfunction

        function bit [63:0] root(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // returns 0 when the marker gives no usable hit
        function bit ray_gap(marker_item_t it, longint z, output longint d);
            longint x, y, p1x, p1y, p1z, xx, k, m, num, den, t, dx, dy, dz;
            longint ex, ey, ez;
            bit [63:0] sum;
            x   = longint'(it.mx);
            y   = longint'(it.my);
            p1x = longint'(it.hcx);
            p1y = longint'(it.hcy);
            p1z = longint'(it.hcz);
            d   = 0;
            if (x == 0)
                return 0;
            xx = fmul(x, x);
            if (xx == 0)
                return 0;
            k   = sat(fdiv(z, x) + fdiv(fmul(z, y), 2 * xx));
            k   = sat(k + fdiv(z, 2 * xx));
            m   = fdiv(z, 2 * x);
            num = sat(fmul(p1x, k) - fmul(p1y, m));
            num = sat(num - p1z);
            num = sat(num - m);
            dx  = sat(longint'(it.hfx) - p1x);
            dy  = sat(longint'(it.hfy) - p1y);
            dz  = sat(longint'(it.hfz) - p1z);
            den = sat(dz - fmul(dx, k));
            den = sat(den + fmul(dy, m));
            if (den == 0)
                return 0;
            t   = fdiv(num, den);
            ex  = sat(sat(p1x + fmul(t, dx)) - x);
            ey  = sat(sat(p1y + fmul(t, dy)) - y);
            ez  = sat(sat(p1z + fmul(t, dz)) - z);
            sum = ex * ex;
            sum = sum + 64'(ey * ey);
            sum = sum + 64'(ez * ez);
            sum = root(sum);
            d   = (sum > 64'd2147483647) ? 64'sd2147483647 : longint'(sum);
            return 1;
        endfunction

        function void note_marker(marker_item_t it);
            longint  z, d;
            target_t tg;
            int      pos;
            if (count == 0)
                clear_frame();
            z   = ((longint'(it.mm) * 65536) + 500) / 1000;
            pos = count;
            if (pos < gzts_pkg::MARKER_LIMIT)
            begin
                if (it.conf > conf_thr && ray_gap(it, z, d) && d < best_dist)
                begin
                    best_dist = d;
                    best_x    = longint'(it.mx);
                    best_y    = longint'(it.my);
                    best_z    = z;
                    best_idx  = pos;
                    have_best = 1;
                end
                count = pos + 1;
            end
            if (!it.last)
                return;
            if (have_best)
            begin
                tg.ax    = best_x[31:0];
                tg.ay    = best_y[31:0];
                tg.az    = best_z[31:0];
                tg.idx   = best_idx[5:0];
                tg.found = 1'b1;
            end
            else
            begin
                tg.ax    = it.hcx;
                tg.ay    = it.hcy;
                tg.az    = it.hcz;
                tg.idx   = 6'd0;
                tg.found = 1'b0;
            end
            targets_due.push_back(tg);
            clear_frame();
        endfunction

        function void field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $realtime, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_target(target_t got);
            target_t tg;
            if (targets_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0d %0b",
                         $realtime, got.ax, got.ay, got.az, got.idx, got.found);
                errors++;
                return;
            end
            tg = targets_due.pop_front();
            field("attended_x", longint'(tg.ax), longint'(got.ax));
            field("attended_y", longint'(tg.ay), longint'(got.ay));
            field("attended_z", longint'(tg.az), longint'(got.az));
            field("marker_index", longint'(tg.idx), longint'(got.idx));
            field("found", longint'(tg.found), longint'(got.found));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_index = gzts_pkg::CFG_MAX_DIST;
    logic [gzts_pkg::CFG_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] head_center_x = '0, head_center_y = '0, head_center_z = '0;
    logic signed [31:0] head_front_x = '0, head_front_y = '0, head_front_z = '0;
    logic signed [31:0] marker_x = '0, marker_y = '0;
    logic [15:0]        marker_depth_mm = '0;
    logic [30:0]        marker_confidence = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] attended_x, attended_y, attended_z;
    logic [gzts_pkg::IDX_W-1:0] marker_index;
    logic               found;

    frame_scoreboard sb;
    int send_idle_pct = 6;
    int recv_idle_pct = 86;
    int hold_cycles = 0;

    gaze_ray_target_select dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_target('{attended_x, attended_y, attended_z, marker_index, found});
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready   <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic idx, logic [30:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == gzts_pkg::CFG_MAX_DIST)
            sb.max_dist = val;
        else
            sb.conf_thr = val;
    endtask

    task automatic send_marker(marker_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        head_center_x     <= it.hcx;
        head_center_y     <= it.hcy;
        head_center_z     <= it.hcz;
        head_front_x      <= it.hfx;
        head_front_y      <= it.hfy;
        head_front_z      <= it.hfz;
        marker_x          <= it.mx;
        marker_y          <= it.my;
        marker_depth_mm   <= it.mm;
        marker_confidence <= it.conf;
        last              <= it.last;
        in_valid          <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_marker(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.targets_due.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic marker_item_t noise_marker();
        marker_item_t it;
        it.hcx  = $urandom;
        it.hcy  = $urandom;
        it.hcz  = $urandom;
        it.hfx  = $urandom;
        it.hfy  = $urandom;
        it.hfz  = $urandom;
        it.mx   = $urandom;
        it.my   = $urandom;
        it.mm   = 16'($urandom);
        it.conf = 31'($urandom);
        it.last = 1'b0;
        return it;
    endfunction

    // head near origin looking along z, marker 0.2 to 5 m out
    function automatic marker_item_t gaze_marker();
        marker_item_t it;
        int sx;
        it.hcx  = $signed($urandom_range(131072)) - 65536;
        it.hcy  = $signed($urandom_range(131072)) - 65536;
        it.hcz  = $signed($urandom_range(65536)) - 32768;
        it.hfx  = it.hcx + $signed($urandom_range(16384)) - 8192;
        it.hfy  = it.hcy + $signed($urandom_range(16384)) - 8192;
        it.hfz  = it.hcz + $signed($urandom_range(32768, 6554));
        sx      = $urandom_range(1) ? 1 : -1;
        it.mx   = sx * $signed($urandom_range(196608, 6554));
        it.my   = $signed($urandom_range(196608)) - 98304;
        it.mm   = 16'($urandom_range(5000, 200));
        it.conf = 31'($urandom_range(65536, 7000));
        it.last = 1'b0;
        return it;
    endfunction

    task automatic send_frame(int len);
        marker_item_t it;
        int i;
        for (i = 0; i < len; i++)
        begin
            it = ($urandom_range(99) < 80) ? gaze_marker() : noise_marker();
            if ($urandom_range(99) < 8)
                it.conf = 31'($urandom_range(sb.conf_thr));
            it.last = (i == len - 1);
            send_marker(it);
        end
    endtask

    task automatic random_phase(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(59) == 0) ? $urandom_range(72, 65)
                                           : $urandom_range(8, 1);
            send_frame(len);
            sent += len;
        end
        drain();
    endtask

    task automatic directed();
        marker_item_t it;
        marker_item_t base;
        int i;
        base = gaze_marker();
        base.conf = 31'd6554;
        base.last = 1'b1;
        send_marker(base);
        base.conf = 31'd6555;
        send_marker(base);
        base.conf = 31'h7fffffff;
        send_marker(base);
        it = base; it.conf = '0; send_marker(it);
        it = base; it.mx = 0; send_marker(it);
        it = base; it.mx = 32'sd100; send_marker(it);
        it = base; it.mx = -32'sd255; send_marker(it);
        it = base; it.hfx = it.hcx; it.hfy = it.hcy; it.hfz = it.hcz; send_marker(it);
        it = base; it.mm = 16'd0; send_marker(it);
        it = base; it.mm = 16'hffff; send_marker(it);
        it = base; it.last = 1'b0;
        send_marker(it);
        send_marker(base);
        it = base;
        it.hcx = 32'sh80000000; it.hcy = 32'sh7fffffff; it.hcz = 32'sh80000000;
        it.hfx = 32'sh7fffffff; it.hfy = 32'sh80000000; it.hfz = 32'sh7fffffff;
        it.mx  = 32'sh7fffffff; it.my  = 32'sh80000000;
        send_marker(it);
        it.mx = 32'sh80000000; it.my = 32'sh7fffffff; it.hcz = 32'sh7fffffff;
        send_marker(it);
        for (i = 0; i < 66; i++)
        begin
            it = gaze_marker();
            it.last = (i == 65);
            send_marker(it);
        end
        drain();
    endtask

    initial
    begin
        #60ms;
        $display("gaze_ray_target_select test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.reset_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        write_reg(gzts_pkg::CFG_MAX_DIST, 31'h7fffffff);
        write_reg(gzts_pkg::CFG_CONF_THR, 31'd0);
        hold_cycles = 3000;
        random_phase(340);
        write_reg(gzts_pkg::CFG_MAX_DIST, 31'd131072);
        write_reg(gzts_pkg::CFG_CONF_THR, 31'd6554);
        random_phase(340);
        send_idle_pct = 86;
        recv_idle_pct = 6;
        write_reg(gzts_pkg::CFG_MAX_DIST, 31'd0);
        write_reg(gzts_pkg::CFG_CONF_THR, 31'h7fffffff);
        random_phase(200);
        write_reg(gzts_pkg::CFG_MAX_DIST, 31'd32768);
        write_reg(gzts_pkg::CFG_CONF_THR, 31'd20000);
        random_phase(340);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(gzts_pkg::CFG_MAX_DIST, 31'h7fffffff);
        write_reg(gzts_pkg::CFG_CONF_THR, 31'd6554);
        random_phase(360);
        if (sb.errors == 0 && sb.targets_due.size() == 0)
            $display("gaze_ray_target_select test passed");
        else
            $display("gaze_ray_target_select test failed");
        $finish;
    end

endmodule
